// ----- rtl/isf_pkg.sv -----
// Shared types and constants for the interval screen filter.
// Used by isf_front, isf_queue, isf_back and interval_screen_filter.
// No dependencies.
package isf_pkg;

  localparam int SCREEN_DEPTH = 256;
  localparam int IDX_W        = (SCREEN_DEPTH > 1) ? $clog2(SCREEN_DEPTH) : 1;
  localparam int CNT_W        = $clog2(SCREEN_DEPTH + 1);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ACT_W        = 9;
  localparam int CFG_DATA_W   = 9;
  localparam int CFG_IDX_W    = 1;
  localparam int POS_W        = 32;
  localparam int TS_W         = 64;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COUNT = 1'b1;

  // action codes carried by an input item
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_SCREEN = 2'd1;
  localparam logic [1:0] ACT_BATCH  = 2'd2;

  localparam logic MODE_CONTAIN = 1'b0;
  localparam logic MODE_EXCLUDE = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SCREEN,
    OP_BATCH
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic [1:0]             action;
    logic [7:0]             entry_index;
    logic signed [TS_W-1:0] start_time;
    logic signed [TS_W-1:0] stop_time;
    logic signed [TS_W-1:0] extra_value;
  } item_t;

  typedef struct packed {
    logic signed [TS_W-1:0] kept_start;
    logic signed [TS_W-1:0] kept_stop;
    logic signed [TS_W-1:0] kept_extra;
    logic [POS_W-1:0]       kept_position;
  } result_t;

  typedef struct packed {
    op_t                    op;
    logic                   load_ok;
    logic [IDX_W-1:0]       slot;
    logic signed [TS_W-1:0] start_time;
    logic signed [TS_W-1:0] stop_time;
    logic signed [TS_W-1:0] extra_value;
  } queue_entry_t;

  typedef struct packed {
    logic signed [TS_W-1:0] start_time;
    logic signed [TS_W-1:0] stop_time;
  } screen_entry_t;

  typedef struct packed {
    back_state_t      state;
    logic [CNT_W-1:0] scan_idx;
    logic [CNT_W-1:0] scan_limit;
  } back_status_t;

endpackage

// ----- rtl/isf_front.sv -----
// Front end: accepts input transactions, decodes the action and pushes work
// into the queue. Depends on isf_pkg.
module isf_front (
  input  logic                 item_valid,
  output logic                 item_ready,
  input  isf_pkg::item_t       item,
  output logic                 push_valid,
  input  logic                 push_ready,
  output isf_pkg::queue_entry_t push_entry
);
  import isf_pkg::*;

  logic known;
  op_t  op;

  always_comb begin
    known = 1'b1;
    op    = OP_LOAD;
    unique case (item.action)
      ACT_LOAD:   op = OP_LOAD;
      ACT_SCREEN: op = OP_SCREEN;
      ACT_BATCH:  op = OP_BATCH;
      default:    known = 1'b0;
    endcase
  end

  // drop unused actions here, they never reach the back end
  assign item_ready = push_ready || !known;
  assign push_valid = item_valid && known;

  always_comb begin
    push_entry.op          = op;
    push_entry.load_ok     = (32'(item.entry_index) < SCREEN_DEPTH);
    push_entry.slot        = IDX_W'(item.entry_index);
    push_entry.start_time  = item.start_time;
    push_entry.stop_time   = item.stop_time;
    push_entry.extra_value = item.extra_value;
  end

endmodule

// ----- rtl/isf_queue.sv -----
// Short FIFO between the front end and the back end.
// Depends on isf_pkg for the entry type and depth.
module isf_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  isf_pkg::queue_entry_t push_entry,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output isf_pkg::queue_entry_t pop_entry
);
  import isf_pkg::*;

  queue_entry_t      slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/isf_back.sv -----
// Back end: holds the screen table, performs loads and batch starts, scans
// the table one entry per cycle for each candidate and registers results.
// Depends on isf_pkg.
module isf_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  isf_pkg::queue_entry_t          pop_entry,
  input  logic                           screen_mode,
  input  logic [isf_pkg::ACT_W-1:0]      active_count,
  output logic                           result_valid,
  input  logic                           result_ready,
  output isf_pkg::result_t               result,
  output isf_pkg::back_status_t          status
);
  import isf_pkg::*;

  screen_entry_t          screen_mem [SCREEN_DEPTH];
  screen_entry_t          rd_data;
  back_state_t            state;
  back_state_t            state_next;
  logic [CNT_W-1:0]       scan_idx;
  logic [CNT_W-1:0]       scan_limit;
  logic                   pend;
  logic                   rd_en;
  logic                   mem_we;
  logic                   emit;
  logic                   contain_hit;
  logic                   exclude_hit;
  logic                   decisive;
  logic signed [TS_W-1:0] cand_start;
  logic signed [TS_W-1:0] cand_stop;
  logic signed [TS_W-1:0] cand_extra;
  logic [POS_W-1:0]       kept_counter;

  // entries beyond the table are never scanned
  always_comb begin
    if (32'(active_count) > SCREEN_DEPTH) begin
      scan_limit = CNT_W'(SCREEN_DEPTH);
    end else begin
      scan_limit = CNT_W'(active_count);
    end
  end

  assign contain_hit = ($signed(rd_data.start_time) <= $signed(cand_start)) &&
                       ($signed(cand_stop) <= $signed(rd_data.stop_time));
  assign exclude_hit = (($signed(rd_data.start_time) <= $signed(cand_start)) &&
                        ($signed(cand_start) <= $signed(rd_data.stop_time))) ||
                       (($signed(rd_data.start_time) <= $signed(cand_stop)) &&
                        ($signed(cand_stop) <= $signed(rd_data.stop_time)));
  assign decisive    = (screen_mode == MODE_EXCLUDE) ? exclude_hit : contain_hit;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop_valid && pop_entry.op == OP_SCREEN) begin
          if (scan_limit == '0) begin
            state_next = (screen_mode == MODE_EXCLUDE) ? ST_EMIT : ST_IDLE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (pend && decisive) begin
          state_next = (screen_mode == MODE_EXCLUDE) ? ST_IDLE : ST_EMIT;
        end else if (!pend && scan_idx == scan_limit) begin
          state_next = (screen_mode == MODE_EXCLUDE) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_ready = 1'b0;
    rd_en     = 1'b0;
    emit      = 1'b0;
    unique case (state)
      ST_IDLE: pop_ready = 1'b1;
      ST_SCAN: rd_en     = (scan_idx < scan_limit);
      ST_EMIT: emit      = !result_valid || result_ready;
      default: pop_ready = 1'b0;
    endcase
  end

  assign mem_we = pop_valid && pop_ready && pop_entry.op == OP_LOAD && pop_entry.load_ok;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[pop_entry.slot] <= '{start_time: pop_entry.start_time,
                                      stop_time:  pop_entry.stop_time};
    end
    if (rd_en) begin
      rd_data <= screen_mem[scan_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      scan_idx     <= '0;
      pend         <= 1'b0;
      kept_counter <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= rd_en;
      if (state == ST_IDLE) begin
        scan_idx <= '0;
      end else if (rd_en) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (pop_valid && pop_ready && pop_entry.op == OP_BATCH) begin
        kept_counter <= '0;
      end else if (emit && kept_counter != '1) begin
        kept_counter <= kept_counter + 1'b1;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // hold the candidate while it is scanned
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cand_start <= pop_entry.start_time;
      cand_stop  <= pop_entry.stop_time;
      cand_extra <= pop_entry.extra_value;
    end
    if (emit) begin
      result.kept_start    <= cand_start;
      result.kept_stop     <= cand_stop;
      result.kept_extra    <= cand_extra;
      result.kept_position <= kept_counter;
    end
  end

  always_comb begin
    status.state      = state;
    status.scan_idx   = scan_idx;
    status.scan_limit = scan_limit;
  end

endmodule

// ----- rtl/interval_screen_filter.sv -----
// Interval screen filter: a screen table of SCREEN_DEPTH start/stop pairs is
// loaded by index, then candidate intervals are screened against entries 0 to
// active_count-1, clamped to the table size, and kept candidates are returned
// with their position in the compacted output. A load or batch start takes
// effect when the back end takes it from the queue, and an unused action is
// dropped in the cycle it is accepted. A candidate's scan reads one table
// entry per cycle through the single read port of the screen memory and ends
// early on a decisive match. The front end keeps accepting transactions into
// a two-entry queue while the back end scans, and a finished result waits in
// the output register without stalling the scan.
// Top level; depends on isf_pkg, isf_front, isf_queue and isf_back.
module interval_screen_filter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  isf_pkg::item_t                     item,
  output logic                               result_valid,
  input  logic                               result_ready,
  output isf_pkg::result_t                   result,
  input  logic                               cfg_write,
  input  logic [isf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [isf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import isf_pkg::*;

  logic         screen_mode;
  logic [ACT_W-1:0] active_count;
  logic         push_valid;
  logic         push_ready;
  queue_entry_t push_entry;
  logic         pop_valid;
  logic         pop_ready;
  queue_entry_t pop_entry;
  back_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_mode  <= MODE_CONTAIN;
      active_count <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCREEN_MODE:  screen_mode  <= cfg_data[0];
        REG_ACTIVE_COUNT: active_count <= ACT_W'(cfg_data);
        default:          screen_mode  <= screen_mode;
      endcase
    end
  end

  isf_front u_front (
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  isf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  isf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_entry    (pop_entry),
    .screen_mode  (screen_mode),
    .active_count (active_count),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .status       (status)
  );

  // no new work is taken while a result is waiting to be registered
  a_no_pop_in_emit: assert property (@(posedge clk) disable iff (rst)
    (status.state == ST_EMIT) |-> !(pop_valid && pop_ready))
    else $error("queue popped while a result is pending");

  // the scan never runs past the clamped table size
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (status.state == ST_SCAN) |-> (status.scan_idx <= status.scan_limit))
    else $error("scan index beyond active entries");

  // a result only appears after the emit step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(status.state) == ST_EMIT))
    else $error("result raised outside emit");

endmodule

// ----- tb/interval_screen_filter_tb.sv -----
// Self-checking testbench for interval_screen_filter: directed table, then random phases
// over screen modes and active counts, checked against an in-bench predictor.
// Depends on isf_pkg and the interval_screen_filter RTL.
`timescale 1ns / 1ps

module interval_screen_filter_tb;
  import isf_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 780;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic signed [TS_W-1:0] TS_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [TS_W-1:0] TS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_GIVEN} check_kind_t;

  typedef struct {
    logic        is_cfg;
    logic        cfg_mode;
    logic [8:0]  cfg_count;
    item_t       it;
    check_kind_t chk;
    result_t     res;
  } stim_row_t;

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_ready;
  item_t            item;
  logic             result_valid;
  logic             result_ready;
  result_t          result;
  logic             cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  interval_screen_filter dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // predictor state
  logic signed [TS_W-1:0] screen_lo [SCREEN_DEPTH];
  logic signed [TS_W-1:0] screen_hi [SCREEN_DEPTH];
  logic                   loaded    [SCREEN_DEPTH];
  logic [POS_W-1:0]       kept_count;
  logic                   cur_mode;
  logic [8:0]             cur_active;

  result_t     pending_kept [$];
  int unsigned faults;
  int unsigned cycle_count;
  int unsigned n_loads, n_screens, n_batches, n_ignored, n_kept, n_settings;
  int unsigned burst_left;
  logic        steady_phase;
  logic        driving;
  int unsigned stall_style;
  logic [3:0]  stall_tick;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_kept.size());
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: switch stall style now and then
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b1;
      stall_style  <= 0;
      stall_tick   <= '0;
    end else begin
      stall_tick <= stall_tick + 4'd1;
      if ($urandom_range(0, 199) == 0) stall_style <= $urandom_range(0, 3);
      case (stall_style)
        0: result_ready <= 1'b1;
        1: result_ready <= 1'($urandom_range(0, 1));
        2: result_ready <= ($urandom_range(0, 4) == 0);
        default: result_ready <= (stall_tick < 4'd11);
      endcase
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      n_kept++;
      if (pending_kept.size() == 0) begin
        $error("result with nothing expected: start %0d stop %0d", result.kept_start,
               result.kept_stop);
        faults++;
      end else begin
        want = pending_kept.pop_front();
        if (result.kept_start !== want.kept_start) begin
          $error("kept_start: expected %0d, got %0d", want.kept_start, result.kept_start);
          faults++;
        end
        if (result.kept_stop !== want.kept_stop) begin
          $error("kept_stop: expected %0d, got %0d", want.kept_stop, result.kept_stop);
          faults++;
        end
        if (result.kept_extra !== want.kept_extra) begin
          $error("kept_extra: expected %0d, got %0d", want.kept_extra, result.kept_extra);
          faults++;
        end
        if (result.kept_position !== want.kept_position) begin
          $error("kept_position: expected %0d, got %0d", want.kept_position,
                 result.kept_position);
          faults++;
        end
      end
    end
  end

  function automatic int table_span();
    return (cur_active > SCREEN_DEPTH) ? SCREEN_DEPTH : int'(cur_active);
  endfunction

  // up to three candidates in flight, each a full scan
  function automatic int settle_cycles();
    return 3 * (table_span() + 6) + 16;
  endfunction

  // advance the predictor by one transaction; returns 1 when a result is due
  function automatic logic screen_item(input item_t it, output result_t res);
    int   span;
    logic keep;
    span = table_span();
    keep = 1'b0;
    res  = '0;
    case (it.action)
      ACT_LOAD: begin
        screen_lo[it.entry_index] = it.start_time;
        screen_hi[it.entry_index] = it.stop_time;
        loaded[it.entry_index]    = 1'b1;
      end
      ACT_BATCH: kept_count = '0;
      ACT_SCREEN: begin
        if (cur_mode == MODE_CONTAIN) begin
          for (int j = 0; j < span; j++) begin
            if (screen_lo[j] <= it.start_time && it.stop_time <= screen_hi[j]) begin
              keep = 1'b1;
              break;
            end
          end
        end else begin
          keep = 1'b1;
          for (int j = 0; j < span; j++) begin
            if ((screen_lo[j] <= it.start_time && it.start_time <= screen_hi[j]) ||
                (screen_lo[j] <= it.stop_time && it.stop_time <= screen_hi[j])) begin
              keep = 1'b0;
              break;
            end
          end
        end
        if (keep) begin
          res = '{it.start_time, it.stop_time, it.extra_value, kept_count};
          if (kept_count != '1) kept_count++;
        end
      end
      default: ;
    endcase
    return keep;
  endfunction

  function automatic stim_row_t item_row(input logic [1:0] act, input logic [7:0] idx,
                                         input logic signed [TS_W-1:0] s, e, x,
                                         input check_kind_t chk = CHK_PREDICT,
                                         input logic [POS_W-1:0] pos = '0);
    stim_row_t r;
    r.is_cfg    = 1'b0;
    r.cfg_mode  = MODE_CONTAIN;
    r.cfg_count = '0;
    r.it        = '{act, idx, s, e, x};
    r.chk       = chk;
    r.res       = '{s, e, x, pos};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic mode, input logic [8:0] count);
    stim_row_t r;
    r           = item_row(ACT_UNUSED, '0, '0, '0, '0, CHK_NONE);
    r.is_cfg    = 1'b1;
    r.cfg_mode  = mode;
    r.cfg_count = count;
    return r;
  endfunction

  function automatic logic signed [TS_W-1:0] rand_stamp();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return TS_MIN + 64'($urandom_range(0, 3));
      2: return TS_MAX - 64'($urandom_range(0, 3));
      default: return 64'($urandom_range(0, 4000)) - 64'd2000;
    endcase
  endfunction

  // mostly candidates near a loaded screen so both outcomes are common
  function automatic item_t random_item();
    item_t it;
    int    span, j, pick;
    span           = table_span();
    pick           = $urandom_range(0, 99);
    it.action      = ACT_SCREEN;
    it.entry_index = 8'($urandom);
    it.start_time  = {$urandom, $urandom};
    it.stop_time   = {$urandom, $urandom};
    it.extra_value = {$urandom, $urandom};
    if (pick < 9) begin
      it.action     = ACT_LOAD;
      it.start_time = rand_stamp();
      it.stop_time  = ($urandom_range(0, 7) == 0) ? rand_stamp()
                      : it.start_time + 64'($urandom_range(0, 300));
    end else if (pick < 13) begin
      it.action = ACT_BATCH;
    end else if (pick < 16) begin
      it.action = ACT_UNUSED;
    end else if (pick < 20) begin
      // keep random wide fields as they are
    end else if (span > 0 && $urandom_range(0, 3) != 0) begin
      j             = $urandom_range(0, span - 1);
      it.start_time = screen_lo[j] + 64'($urandom_range(0, 40)) - 64'd20;
      it.stop_time  = screen_hi[j] + 64'($urandom_range(0, 40)) - 64'd20;
    end else begin
      it.start_time = rand_stamp();
      it.stop_time  = ($urandom_range(0, 3) == 0) ? rand_stamp()
                      : it.start_time + 64'($urandom_range(0, 500));
    end
    return it;
  endfunction

  task automatic drop_valid();
    if (driving) begin
      item_valid <= 1'b0;
      driving = 1'b0;
    end
  endtask

  task automatic wait_drained();
    while (pending_kept.size() != 0) @(posedge clk);
  endtask

  task automatic send(input item_t it, input check_kind_t chk, input result_t given);
    result_t res;
    logic    kept;
    item       <= it;
    item_valid <= 1'b1;
    driving = 1'b1;
    do @(posedge clk); while (!item_ready);
    kept = screen_item(it, res);
    case (chk)
      CHK_PREDICT: if (kept) pending_kept.push_back(res);
      CHK_GIVEN:   pending_kept.push_back(given);
      default: ;
    endcase
    case (it.action)
      ACT_LOAD:   n_loads++;
      ACT_SCREEN: n_screens++;
      ACT_BATCH:  n_batches++;
      default:    n_ignored++;
    endcase
  endtask

  // sender bursts with random gaps between them
  task automatic pace();
    if (steady_phase) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    drop_valid();
    repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 24 : 4)) @(posedge clk);
    burst_left = $urandom_range(0, 15);
  endtask

  task automatic set_config(input logic mode, input logic [8:0] count);
    drop_valid();
    wait_drained();
    repeat (settle_cycles()) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_SCREEN_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    cur_mode = mode;
    cfg_index <= REG_ACTIVE_COUNT;
    cfg_data  <= count;
    @(posedge clk);
    cur_active = count;
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  initial begin
    stim_row_t  directed [$];
    item_t      it;
    int         phase, budget, span;
    int unsigned rand_items;
    logic       mode;
    logic [8:0] count;

    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    driving      = 1'b0;
    steady_phase = 1'b0;
    burst_left   = 0;
    kept_count   = '0;
    cur_mode     = MODE_CONTAIN;
    cur_active   = '0;
    rand_items   = 0;
    foreach (loaded[i]) begin
      loaded[i]    = 1'b0;
      screen_lo[i] = '0;
      screen_hi[i] = '0;
    end

    // empty table in contain mode keeps nothing
    directed.push_back(item_row(ACT_SCREEN, 8'd0, 64'sd0, 64'sd10, 64'sd5, CHK_NONE));
    directed.push_back(item_row(ACT_UNUSED, 8'hFF, TS_MAX, TS_MIN, 64'h0123_4567_89AB_CDEF,
                                CHK_NONE));
    directed.push_back(item_row(ACT_BATCH, 8'h00, TS_MIN, TS_MAX, TS_MIN, CHK_NONE));
    // empty table in exclude mode keeps everything
    directed.push_back(cfg_row(MODE_EXCLUDE, 9'd0));
    directed.push_back(item_row(ACT_SCREEN, 8'hFF, TS_MIN, TS_MAX, TS_MAX, CHK_GIVEN, 32'd0));
    directed.push_back(item_row(ACT_SCREEN, 8'h00, -64'sd1, 64'sd1, TS_MIN, CHK_GIVEN, 32'd1));
    directed.push_back(item_row(ACT_BATCH, 8'hFF, 64'sd0, 64'sd0, 64'sd0, CHK_NONE));
    directed.push_back(item_row(ACT_LOAD, 8'd0, -64'sd100, 64'sd100, 64'sd0, CHK_NONE));
    directed.push_back(item_row(ACT_LOAD, 8'd1, TS_MAX - 64'sd10, TS_MAX, 64'sd0, CHK_NONE));
    directed.push_back(item_row(ACT_LOAD, 8'd2, TS_MIN, TS_MIN + 64'sd10, 64'sd0, CHK_NONE));
    directed.push_back(item_row(ACT_LOAD, 8'd255, 64'hAAAA_AAAA_AAAA_AAAA,
                                64'h5555_5555_5555_5555, TS_MAX, CHK_NONE));
    // reversed screen
    directed.push_back(item_row(ACT_LOAD, 8'd3, 64'sd50, -64'sd50, 64'sd0, CHK_NONE));
    directed.push_back(cfg_row(MODE_EXCLUDE, 9'd4));
    directed.push_back(item_row(ACT_SCREEN, 8'd0, -64'sd100, -64'sd100, 64'sd7));
    directed.push_back(item_row(ACT_SCREEN, 8'd0, -64'sd200, 64'sd200, 64'sd8));
    directed.push_back(item_row(ACT_SCREEN, 8'd0, TS_MIN, TS_MAX, 64'sd9));
    directed.push_back(item_row(ACT_SCREEN, 8'd0, 64'sd200, 64'sd300, TS_MIN));
    directed.push_back(cfg_row(MODE_CONTAIN, 9'd4));
    directed.push_back(item_row(ACT_SCREEN, 8'd0, -64'sd100, 64'sd100, 64'sd1));
    directed.push_back(item_row(ACT_SCREEN, 8'd0, -64'sd101, 64'sd0, 64'sd2));
    directed.push_back(item_row(ACT_SCREEN, 8'd0, TS_MAX, TS_MAX, 64'sd3));
    directed.push_back(item_row(ACT_SCREEN, 8'd0, TS_MIN, TS_MIN, 64'sd4));
    directed.push_back(item_row(ACT_BATCH, 8'd0, 64'sd0, 64'sd0, 64'sd0, CHK_NONE));
    directed.push_back(item_row(ACT_SCREEN, 8'd0, 64'sd200, -64'sd200, TS_MAX));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        set_config(directed[i].cfg_mode, directed[i].cfg_count);
      end else begin
        send(directed[i].it, directed[i].chk, directed[i].res);
        pace();
      end
    end

    phase = 0;
    while (rand_items < RANDOM_ITEMS) begin
      case (phase)
        0: begin mode = MODE_CONTAIN; count = 9'd256; end
        1: begin mode = MODE_EXCLUDE; count = 9'd256; end
        2: begin mode = MODE_CONTAIN; count = 9'd0;   end
        3: begin mode = MODE_EXCLUDE; count = 9'd0;   end
        4: begin mode = MODE_EXCLUDE; count = 9'd511; end
        5: begin mode = MODE_CONTAIN; count = 9'd1;   end
        default: begin
          mode  = 1'($urandom_range(0, 1));
          count = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(17, 256))
                  : 9'($urandom_range(0, 16));
        end
      endcase
      steady_phase = ($urandom_range(0, 3) == 0);
      span = (count > SCREEN_DEPTH) ? SCREEN_DEPTH : int'(count);
      // every slot in use must hold a screen before it is scanned
      for (int s = 0; s < span; s++) begin
        if (!loaded[s]) begin
          it             = random_item();
          it.action      = ACT_LOAD;
          it.entry_index = 8'(s);
          it.start_time  = rand_stamp();
          it.stop_time   = it.start_time + 64'($urandom_range(0, 300));
          send(it, CHK_PREDICT, '0);
          rand_items++;
          pace();
        end
      end
      set_config(mode, count);
      budget = (span > 64) ? 40 : 60;
      for (int k = 0; k < budget; k++) begin
        if (k == budget / 2 && (phase == 0 || $urandom_range(0, 1) == 1)) begin
          drop_valid();
          wait_drained();
          @(posedge clk);
        end
        it = random_item();
        send(it, CHK_PREDICT, '0);
        if (it.action != ACT_UNUSED) rand_items++;
        pace();
      end
      phase++;
    end

    drop_valid();
    wait_drained();
    repeat (settle_cycles()) @(posedge clk);
    $display("Covered %0d loads, %0d screens (%0d kept), %0d batch starts, %0d ignored",
             n_loads, n_screens, n_kept, n_batches, n_ignored);
    $display("across %0d mode and active-count settings in %0d cycles", n_settings,
             cycle_count);
    if (faults == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/isf_pkg.sv
rtl/isf_front.sv
rtl/isf_queue.sv
rtl/isf_back.sv
rtl/interval_screen_filter.sv
tb/interval_screen_filter_tb.sv
